### design/modbus_read_response_checker_top_macros.svh
// assertion macros used by the reply checker's property file
`ifndef MODBUS_READ_RESPONSE_CHECKER_TOP_MACROS_SVH
`define MODBUS_READ_RESPONSE_CHECKER_TOP_MACROS_SVH

// property that must hold at every clock edge outside reset
`define MRRC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// property checked in the cycle after its trigger
`define MRRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### design/mrrc_pkg.sv
// types, constants and helper functions of the read reply checker
package mrrc_pkg;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_SHORT = 3'd1,
    ST_ADDR  = 3'd2,
    ST_FUNC  = 3'd3,
    ST_COUNT = 3'd4,
    ST_CRC   = 3'd5
  } status_e;

  localparam logic [7:0]  FC_READ_HOLD = 8'h03;
  localparam logic [7:0]  BYTE_COUNT   = 8'h04;
  localparam logic [7:0]  ADDR_RESET   = 8'h01;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;
  localparam int          MIN_FRAME    = 9;

  // x / 10 == (x * RECIP10) >> RECIP_SHIFT for every 16-bit x
  localparam logic [15:0] RECIP10     = 16'd52429;
  localparam int          RECIP_SHIFT = 19;
  localparam int          QUOT_W      = 13;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    status_e            status;
    logic [5:0]         length;
    logic signed [15:0] hum;
    logic signed [15:0] temp;
  } frame_rec_t;

  typedef struct packed {
    logic       valid;
    frame_rec_t rec;
  } rec_push_t;

  function automatic logic [15:0] crc8_upd(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic [15:0] mag16(input logic signed [15:0] v);
    logic [15:0] m;
    m = v[15] ? 16'(-v) : 16'(v);
    return m;
  endfunction

endpackage

### design/mrrc_stream_if.sv
// request channels of the reply checker: received bytes in, frame results out
interface mrrc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_end;

  modport source (output valid, output rx_byte, output frame_end, input ready);
  modport sink (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface mrrc_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [5:0]         frame_length;
  logic signed [15:0] humidity_raw;
  logic signed [15:0] temperature_raw;
  logic signed [12:0] humidity_whole;
  logic [3:0]         humidity_tenths;
  logic signed [12:0] temperature_whole;
  logic [3:0]         temperature_tenths;

  modport source (output valid, output status, output frame_length, output humidity_raw,
                  output temperature_raw, output humidity_whole, output humidity_tenths,
                  output temperature_whole, output temperature_tenths, input ready);
  modport sink (input valid, input status, input frame_length, input humidity_raw,
                input temperature_raw, input humidity_whole, input humidity_tenths,
                input temperature_whole, input temperature_tenths, output ready);
endinterface

### design/mrrc_front.sv
// byte front end: crc, header checks and field capture, one record per frame
module mrrc_front import mrrc_pkg::*; #(
  parameter int MAX_FRAME = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_data_i,
  input  logic       acc_i,
  input  logic [7:0] rx_byte_i,
  input  logic       frame_end_i,
  output rec_push_t  push_o
);

  localparam int POS_W = $clog2(MAX_FRAME + 1);
  localparam logic [POS_W-1:0] P_MAX  = POS_W'(MAX_FRAME);
  localparam logic [POS_W-1:0] P_ADDR = POS_W'(0);
  localparam logic [POS_W-1:0] P_FUNC = POS_W'(1);
  localparam logic [POS_W-1:0] P_CNT  = POS_W'(2);
  localparam logic [POS_W-1:0] P_R1H  = POS_W'(3);
  localparam logic [POS_W-1:0] P_R1L  = POS_W'(4);
  localparam logic [POS_W-1:0] P_R2H  = POS_W'(5);
  localparam logic [POS_W-1:0] P_R2L  = POS_W'(6);
  localparam logic [POS_W-1:0] P_CRCL = POS_W'(7);
  localparam logic [POS_W-1:0] P_CRCH = POS_W'(8);
  localparam logic [POS_W-1:0] P_MIN  = POS_W'(MIN_FRAME);

  logic [7:0]       addr_q;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [15:0]      crc_q, crc_d;
  logic [15:0]      rcrc_q, rcrc_d;
  logic [15:0]      reg1_q, reg1_d;
  logic [15:0]      reg2_q, reg2_d;
  status_e          err_q, err_d;
  logic [POS_W+5:0] len_ext;
  status_e          status;

  always_comb begin
    pos_d   = pos_q;
    crc_d   = crc_q;
    rcrc_d  = rcrc_q;
    reg1_d  = reg1_q;
    reg2_d  = reg2_q;
    err_d   = err_q;
    status  = ST_OK;
    len_ext = '0;
    push_o  = '0;
    if (acc_i) begin
      if (pos_q < P_MAX) begin
        if (pos_q < P_CRCL) begin
          crc_d = crc8_upd(crc_q, rx_byte_i);
        end
        case (pos_q)
          P_ADDR: if (rx_byte_i != addr_q && err_q == ST_OK) err_d = ST_ADDR;
          P_FUNC: if (rx_byte_i != FC_READ_HOLD && err_q == ST_OK) err_d = ST_FUNC;
          P_CNT:  if (rx_byte_i != BYTE_COUNT && err_q == ST_OK) err_d = ST_COUNT;
          P_R1H:  reg1_d[15:8] = rx_byte_i;
          P_R1L:  reg1_d[7:0]  = rx_byte_i;
          P_R2H:  reg2_d[15:8] = rx_byte_i;
          P_R2L:  reg2_d[7:0]  = rx_byte_i;
          P_CRCL: rcrc_d[7:0]  = rx_byte_i;
          P_CRCH: rcrc_d[15:8] = rx_byte_i;
          default: ;
        endcase
        pos_d = pos_q + POS_W'(1);
      end
      if (frame_end_i) begin
        // short frame wins over any header mismatch already seen
        if (pos_d < P_MIN) begin
          status = ST_SHORT;
        end else if (err_d != ST_OK) begin
          status = err_d;
        end else if (crc_d != rcrc_d) begin
          status = ST_CRC;
        end else begin
          status = ST_OK;
        end
        // length of this frame, taken before the count is cleared
        len_ext           = {6'b0, pos_d};
        push_o.valid      = 1'b1;
        push_o.rec.status = status;
        push_o.rec.length = len_ext[5:0];
        push_o.rec.hum    = (status == ST_OK) ? reg1_d : 16'h0000;
        push_o.rec.temp   = (status == ST_OK) ? reg2_d : 16'h0000;
        pos_d  = '0;
        crc_d  = CRC_INIT;
        rcrc_d = '0;
        reg1_d = '0;
        reg2_d = '0;
        err_d  = ST_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= ADDR_RESET;
      pos_q  <= '0;
      crc_q  <= CRC_INIT;
      rcrc_q <= '0;
      reg1_q <= '0;
      reg2_q <= '0;
      err_q  <= ST_OK;
    end else begin
      if (cfg_we_i) begin
        addr_q <= cfg_data_i;
      end
      pos_q  <= pos_d;
      crc_q  <= crc_d;
      rcrc_q <= rcrc_d;
      reg1_q <= reg1_d;
      reg2_q <= reg2_d;
      err_q  <= err_d;
    end
  end

endmodule

### design/mrrc_fifo.sv
// short record queue between the byte front end and the result back end
module mrrc_fifo import mrrc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  rec_push_t  push_i,
  output logic       full_o,
  output logic       pop_valid_o,
  input  logic       pop_i,
  output frame_rec_t pop_rec_o
);

  frame_rec_t        mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign full_o      = (cnt_q == QCNT_W'(QDEPTH));
  assign pop_valid_o = (cnt_q != '0);
  assign pop_rec_o   = mem_q[rd_ptr_q];
  assign do_push     = push_i.valid && !full_o;
  assign do_pop      = pop_i && pop_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.rec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

endmodule

### design/mrrc_back.sv
// result back end: divide by ten in two stages, output register
module mrrc_back import mrrc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rec_valid_i,
  input  frame_rec_t rec_i,
  output logic       pop_o,
  mrrc_out_if.source res_o
);

  logic        s1_v_q;
  frame_rec_t  s1_rec_q;
  logic [31:0] s1_hprod_q, s1_tprod_q;
  logic        out_v_q;
  logic        out_free, s1_load;

  logic [15:0]        hmag, tmag, hmag1, tmag1;
  logic [QUOT_W-1:0]  hq, tq;
  logic [15:0]        hrem, trem;
  logic signed [12:0] hwhole, twhole;

  assign out_free = !out_v_q || res_o.ready;
  assign s1_load  = !s1_v_q || out_free;
  assign pop_o    = s1_load && rec_valid_i;

  assign hmag = mag16(rec_i.hum);
  assign tmag = mag16(rec_i.temp);

  // quotient from the registered products, remainder by shift-and-add
  assign hmag1  = mag16(s1_rec_q.hum);
  assign tmag1  = mag16(s1_rec_q.temp);
  assign hq     = s1_hprod_q[RECIP_SHIFT +: QUOT_W];
  assign tq     = s1_tprod_q[RECIP_SHIFT +: QUOT_W];
  assign hrem   = hmag1 - ({hq, 3'b000} + {2'b00, hq, 1'b0});
  assign trem   = tmag1 - ({tq, 3'b000} + {2'b00, tq, 1'b0});
  assign hwhole = s1_rec_q.hum[15] ? -$signed(hq) : $signed(hq);
  assign twhole = s1_rec_q.temp[15] ? -$signed(tq) : $signed(tq);

  always_ff @(posedge clk_i) begin
    if (s1_load && rec_valid_i) begin
      s1_rec_q   <= rec_i;
      s1_hprod_q <= {16'h0000, hmag} * {16'h0000, RECIP10};
      s1_tprod_q <= {16'h0000, tmag} * {16'h0000, RECIP10};
    end
    if (out_free && s1_v_q) begin
      res_o.status             <= s1_rec_q.status;
      res_o.frame_length       <= s1_rec_q.length;
      res_o.humidity_raw       <= s1_rec_q.hum;
      res_o.temperature_raw    <= s1_rec_q.temp;
      res_o.humidity_whole     <= hwhole;
      res_o.humidity_tenths    <= hrem[3:0];
      res_o.temperature_whole  <= twhole;
      res_o.temperature_tenths <= trem[3:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_v_q <= rec_valid_i;
      end
      if (out_free) begin
        out_v_q <= s1_v_q;
      end
    end
  end

  assign res_o.valid = out_v_q;

endmodule

### design/modbus_read_response_checker_top.sv
// top level of the modbus read-holding reply checker
//
//   channel   dir  handshake            content
//   rx_i      in   valid/ready          rx_byte, frame_end
//   res_o     out  valid/ready          status, length, readings, whole/tenths
//   cfg       in   cfg_we_i             expected slave address
//
// one byte per clock unless stalled; the crc-16 byte update and header checks
// finish in the cycle a byte is taken. a frame result goes through a two-entry
// record queue and a registered multiply-then-correct divide by ten.
// rx_i.ready drops only while the queue holds two records the result side
// has not taken. reset sets the expected address to 1 and clears frame state.
module modbus_read_response_checker_top import mrrc_pkg::*; #(
  parameter int MAX_FRAME = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_data_i,
  mrrc_in_if.sink    rx_i,
  mrrc_out_if.source res_o
);

  rec_push_t  push;
  logic       full, rec_valid, pop;
  frame_rec_t rec;
  logic       acc;

  assign rx_i.ready = !full;
  assign acc        = rx_i.valid && !full;

  mrrc_front #(
    .MAX_FRAME (MAX_FRAME)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .acc_i       (acc),
    .rx_byte_i   (rx_i.rx_byte),
    .frame_end_i (rx_i.frame_end),
    .push_o      (push)
  );

  mrrc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .pop_valid_o (rec_valid),
    .pop_i       (pop),
    .pop_rec_o   (rec)
  );

  mrrc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (rec_valid),
    .rec_i       (rec),
    .pop_o       (pop),
    .res_o       (res_o)
  );

endmodule

### design/mrrc_checker.sv
// port-level properties of the reply checker and their bind
`include "modbus_read_response_checker_top_macros.svh"

module mrrc_checker import mrrc_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid,
  input logic               out_ready,
  input logic [2:0]         status,
  input logic signed [15:0] hum_raw,
  input logic signed [15:0] temp_raw,
  input logic signed [12:0] hum_whole,
  input logic [3:0]         hum_tenths,
  input logic signed [12:0] temp_whole,
  input logic [3:0]         temp_tenths
);

  // a stalled request keeps its status and raw readings
  `MRRC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid && $stable(status) && $stable(hum_raw) && $stable(temp_raw))

  // failed frames carry no readings
  `MRRC_ASSERT(a_fail_zero, clk_i, rst_ni, !(out_valid && status != ST_OK) || (hum_raw == 16'sd0 && temp_raw == 16'sd0 && hum_whole == 13'sd0 && temp_whole == 13'sd0 && hum_tenths == 4'd0 && temp_tenths == 4'd0))

  // tenths stay a decimal digit
  `MRRC_ASSERT(a_tenths_digit, clk_i, rst_ni, !out_valid || (hum_tenths <= 4'd9 && temp_tenths <= 4'd9))

  // a negative raw reading gives a whole part of zero or below
  `MRRC_ASSERT(a_whole_sign, clk_i, rst_ni, !out_valid || ((hum_whole <= 13'sd0 || !hum_raw[15]) && (temp_whole <= 13'sd0 || !temp_raw[15])))

endmodule

bind modbus_read_response_checker_top mrrc_checker u_mrrc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid   (res_o.valid),
  .out_ready   (res_o.ready),
  .status      (res_o.status),
  .hum_raw     (res_o.humidity_raw),
  .temp_raw    (res_o.temperature_raw),
  .hum_whole   (res_o.humidity_whole),
  .hum_tenths  (res_o.humidity_tenths),
  .temp_whole  (res_o.temperature_whole),
  .temp_tenths (res_o.temperature_tenths)
);

### bench/tb.sv
// testbench of the modbus reply checker: random and directed frames checked against a predictor
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mrrc_pkg::*;

  localparam int FRAME_CAP    = 32;
  localparam int IDLE_LIMIT   = 3000;
  localparam int RANDOM_BYTES = 1780;
  localparam int MAX_PRINTS   = 100;

  typedef struct {
    status_e            status;
    logic [5:0]         length;
    logic signed [15:0] hum;
    logic signed [15:0] temp;
    logic signed [12:0] hum_whole;
    logic [3:0]         hum_tenths;
    logic signed [12:0] temp_whole;
    logic [3:0]         temp_tenths;
  } frame_result_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we;
  logic [7:0] cfg_data;

  mrrc_in_if  rx_if ();
  mrrc_out_if res_if ();

  modbus_read_response_checker_top #(
    .MAX_FRAME(FRAME_CAP)
  ) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_data_i(cfg_data),
    .rx_i      (rx_if),
    .res_o     (res_if)
  );

  // predictor state of the frame being received
  int          rx_count;
  logic [15:0] crc_run;
  logic [15:0] crc_seen;
  logic [15:0] hum_reg;
  logic [15:0] temp_reg;
  status_e     header_fault;
  logic [7:0]  slave_addr;

  frame_result_t pending_readings[$];
  logic [7:0]    frame_bytes[$];

  int mismatches  = 0;
  int bytes_sent  = 0;
  int idle_cycles = 0;
  int hold_left   = 0;
  int stall_left  = 0;
  bit tx_idle     = 1'b0;
  bit rx_idle     = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 3);
  endfunction

  function automatic logic [15:0] pick_reg();
    case ($urandom_range(0, 11))
      0: return 16'h0000;
      1: return 16'h7FFF;
      2: return 16'h8000;
      3: return 16'hFFFF;
      4: return 16'h0001;
      5: return 16'hFFF6;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic flag_mismatch(input string msg);
    if (mismatches < MAX_PRINTS) $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic signed [31:0] got,
                             input logic signed [31:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  task automatic restart_frame();
    rx_count     = 0;
    crc_run      = CRC_INIT;
    crc_seen     = 16'h0000;
    hum_reg      = 16'h0000;
    temp_reg     = 16'h0000;
    header_fault = ST_OK;
  endtask

  task automatic note_fault(input status_e code);
    if (header_fault == ST_OK) header_fault = code;
  endtask

  // advance the predicted frame by one byte; on the last byte queue its result
  task automatic absorb_byte(input logic [7:0] b, input logic last);
    frame_result_t r;
    int h;
    int t;
    if (rx_count < FRAME_CAP) begin
      if (rx_count < 7) crc_run = crc16_step(crc_run, b);
      case (rx_count)
        0: if (b != slave_addr) note_fault(ST_ADDR);
        1: if (b != FC_READ_HOLD) note_fault(ST_FUNC);
        2: if (b != BYTE_COUNT) note_fault(ST_COUNT);
        3: hum_reg[15:8] = b;
        4: hum_reg[7:0] = b;
        5: temp_reg[15:8] = b;
        6: temp_reg[7:0] = b;
        7: crc_seen[7:0] = b;
        8: crc_seen[15:8] = b;
        default: ;
      endcase
      rx_count++;
    end
    if (!last) return;
    if (rx_count < MIN_FRAME) r.status = ST_SHORT;
    else if (header_fault != ST_OK) r.status = header_fault;
    else if (crc_run != crc_seen) r.status = ST_CRC;
    else r.status = ST_OK;
    r.length      = 6'(rx_count);
    r.hum         = '0;
    r.temp        = '0;
    r.hum_whole   = '0;
    r.hum_tenths  = '0;
    r.temp_whole  = '0;
    r.temp_tenths = '0;
    if (r.status == ST_OK) begin
      h             = int'($signed(hum_reg));
      t             = int'($signed(temp_reg));
      r.hum         = hum_reg;
      r.temp        = temp_reg;
      r.hum_whole   = 13'(h / 10);
      r.temp_whole  = 13'(t / 10);
      r.hum_tenths  = 4'((h < 0 ? -h : h) % 10);
      r.temp_tenths = 4'((t < 0 ? -t : t) % 10);
    end
    pending_readings.push_back(r);
    restart_frame();
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    @(negedge clk_i);
    rx_if.valid     <= 1'b1;
    rx_if.rx_byte   <= b;
    rx_if.frame_end <= last;
    do @(posedge clk_i); while (rx_if.ready !== 1'b1);
    absorb_byte(b, last);
    bytes_sent++;
    gap = (tx_idle && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      rx_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  task automatic make_reply(input logic [7:0] addr, input logic [7:0] fc, input logic [7:0] cnt,
                            input logic [15:0] h, input logic [15:0] t);
    logic [15:0] c;
    frame_bytes.delete();
    frame_bytes.push_back(addr);
    frame_bytes.push_back(fc);
    frame_bytes.push_back(cnt);
    frame_bytes.push_back(h[15:8]);
    frame_bytes.push_back(h[7:0]);
    frame_bytes.push_back(t[15:8]);
    frame_bytes.push_back(t[7:0]);
    c = CRC_INIT;
    foreach (frame_bytes[i]) c = crc16_step(c, frame_bytes[i]);
    frame_bytes.push_back(c[7:0]);
    frame_bytes.push_back(c[15:8]);
  endtask

  task automatic append_noise(input int n);
    repeat (n) frame_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // flip bits in one part of a well-formed reply
  task automatic corrupt_field(input int which);
    int idx;
    case (which)
      0: idx = 0;
      1: idx = 1;
      2: idx = 2;
      3: idx = $urandom_range(7, 8);
      default: idx = $urandom_range(3, 6);
    endcase
    frame_bytes[idx] = frame_bytes[idx] ^ 8'($urandom_range(1, 255));
  endtask

  task automatic build_random_frame();
    int kind;
    int cut;
    kind = $urandom_range(0, 99);
    make_reply(slave_addr, FC_READ_HOLD, BYTE_COUNT, pick_reg(), pick_reg());
    if (kind < 45) begin
      if ($urandom_range(0, 4) == 0) append_noise($urandom_range(1, 4));
      // overflow the frame buffer now and then
      if ($urandom_range(0, 24) == 0) append_noise($urandom_range(24, 35));
    end else if (kind < 75) begin
      corrupt_field($urandom_range(0, 4));
      if ($urandom_range(0, 2) == 0) corrupt_field($urandom_range(0, 4));
    end else if (kind < 88) begin
      if ($urandom_range(0, 1) == 0) corrupt_field($urandom_range(0, 2));
      cut = $urandom_range(1, 8);
      while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
    end else begin
      frame_bytes.delete();
      append_noise($urandom_range(1, 14));
    end
  endtask

  task automatic drain_readings();
    @(negedge clk_i);
    rx_if.valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_slave_addr(input logic [7:0] addr);
    drain_readings();
    // let a byte without frame end settle before touching the register
    repeat (4) @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_data <= addr;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    slave_addr = addr;
  endtask

  task automatic test_directed_frames();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    make_reply(ADDR_RESET, FC_READ_HOLD, BYTE_COUNT, 16'h8000, 16'h7FFF);
    send_frame();
    // one-byte frame with a wrong address: too short wins
    frame_bytes.delete();
    frame_bytes.push_back(8'h00);
    send_frame();
    // negative readings, plus one byte past the ninth
    make_reply(ADDR_RESET, FC_READ_HOLD, BYTE_COUNT, 16'hFFFF, 16'hFFF6);
    frame_bytes.push_back(8'hFF);
    send_frame();
    drain_readings();
  endtask

  task automatic test_address_register();
    write_slave_addr(8'h00);
    make_reply(8'h00, FC_READ_HOLD, BYTE_COUNT, 16'h0123, 16'hFEDC);
    send_frame();
    make_reply(ADDR_RESET, FC_READ_HOLD, BYTE_COUNT, 16'h0123, 16'hFEDC);
    send_frame();
    write_slave_addr(8'hFF);
    make_reply(8'hFF, FC_READ_HOLD, BYTE_COUNT, 16'h0010, 16'h0200);
    send_frame();
    make_reply(8'hFE, FC_READ_HOLD, BYTE_COUNT, 16'h0010, 16'h0200);
    send_frame();
    write_slave_addr(ADDR_RESET);
  endtask

  task automatic test_output_stall();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    hold_left = 300;
    // one-byte frames each make a result, so the record queue fills fast
    repeat (12) begin
      frame_bytes.delete();
      append_noise(1);
      send_frame();
    end
    make_reply(ADDR_RESET, FC_READ_HOLD, BYTE_COUNT, pick_reg(), pick_reg());
    send_frame();
    drain_readings();
    rx_idle = 1'b1;
    repeat (4) begin
      build_random_frame();
      send_frame();
      drain_readings();
    end
  endtask

  task automatic test_random_replies();
    int frames;
    frames = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      if (frames % 20 == 0) begin
        tx_idle = $urandom_range(0, 2) != 0;
        rx_idle = $urandom_range(0, 2) != 0;
      end
      if (frames % 40 == 39) begin
        case ((frames / 40) % 4)
          0: write_slave_addr(8'h00);
          1: write_slave_addr(8'hFF);
          2: write_slave_addr(8'($urandom_range(0, 255)));
          default: write_slave_addr(ADDR_RESET);
        endcase
      end
      build_random_frame();
      send_frame();
      frames++;
    end
    drain_readings();
  endtask

  // result side: random stalls plus an optional long hold-off
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      res_if.ready <= 1'b0;
    end else if (rx_idle && $urandom_range(0, 4) == 0) begin
      stall_left = pick_gap() - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    frame_result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_readings.size() == 0) begin
        flag_mismatch("result with no frame pending");
      end else begin
        want = pending_readings.pop_front();
        check_field("status", 32'(res_if.status), 32'(want.status));
        check_field("frame_length", 32'(res_if.frame_length), 32'(want.length));
        check_field("humidity_raw", 32'(res_if.humidity_raw), 32'(want.hum));
        check_field("temperature_raw", 32'(res_if.temperature_raw), 32'(want.temp));
        check_field("humidity_whole", 32'(res_if.humidity_whole), 32'(want.hum_whole));
        check_field("humidity_tenths", 32'(res_if.humidity_tenths), 32'(want.hum_tenths));
        check_field("temperature_whole", 32'(res_if.temperature_whole),
                    32'(want.temp_whole));
        check_field("temperature_tenths", 32'(res_if.temperature_tenths),
                    32'(want.temp_tenths));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_data        = 8'h00;
    rx_if.valid     = 1'b0;
    rx_if.rx_byte   = 8'h00;
    rx_if.frame_end = 1'b0;
    slave_addr      = ADDR_RESET;
    restart_frame();
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_frames();
    test_address_register();
    test_output_stall();
    test_random_replies();

    repeat (10) @(posedge clk_i);
    if (pending_readings.size() != 0) flag_mismatch("frame results never arrived");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
